/* rtl/ffba_pkg.sv */
// Shared types, constants and helpers for the first-fit boundary-tag allocator.
package ffba_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int GRANULE_BYTES = 16;
    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int GSHIFT = $clog2(GRANULE_BYTES);
    localparam int BYTES_W = 16;
    localparam int WANT_W = BYTES_W + 1;

    typedef enum logic [1:0] {
        ST_LAST  = 2'd0,
        ST_FREE  = 2'd1,
        ST_INUSE = 2'd2
    } tag_status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic [AW-1:0] size;
        logic [AW-1:0] prev;
        tag_status_t   status;
    } header_t;

    typedef struct packed {
        logic          en;
        logic          we;
        logic [AW-1:0] addr;
        header_t       wdata;
    } mem_req_t;

    typedef struct packed {
        op_t               op;
        logic [WANT_W-1:0] want;
        logic [AW-1:0]     target;
        logic              null_free;
    } cmd_t;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic          status;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT0,
        S_INIT1,
        S_START,
        S_CHK,
        S_A_NX,
        S_A_W1,
        S_A_W2,
        S_F_NX,
        S_F_AF,
        S_F_W1,
        S_F_W2,
        S_DONE
    } walk_state_t;

    // Index of the header that follows header h; one bit wider to flag the heap end.
    function automatic logic [AW:0] follow_hdr(logic [AW-1:0] h, logic [AW-1:0] sz);
        return {1'b0, h} + {{AW{1'b0}}, 1'b1} + {1'b0, sz};
    endfunction

    function automatic logic past_end(logic [AW:0] idx);
        return idx >= (AW+1)'(HEAP_GRANULES);
    endfunction

endpackage

/* rtl/ffba_if.sv */
// Valid/ready channel interfaces for allocator requests and results.
interface ffba_req_if
    import ffba_pkg::*;
();
    logic          valid;
    logic          ready;
    logic          operation;
    logic [15:0]   request_bytes;
    logic [11:0]   block_address;

    modport source (output valid, operation, request_bytes, block_address, input ready);
    modport sink (input valid, operation, request_bytes, block_address, output ready);
endinterface

interface ffba_rsp_if
    import ffba_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [11:0]   granted_address;
    logic          status;

    modport source (output valid, granted_address, status, input ready);
    modport sink (input valid, granted_address, status, output ready);
endinterface

/* rtl/ffba_mem.sv */
// Single-port header store with registered read data.
module ffba_mem
    import ffba_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output header_t  rdata
);

    header_t store [HEAP_GRANULES];

    always_ff @(posedge clk)
    begin
        if (mem_req.en)
        begin
            if (mem_req.we)
            begin
                store[mem_req.addr] <= mem_req.wdata;
            end
            else
            begin
                rdata <= store[mem_req.addr];
            end
        end
    end

endmodule

/* rtl/ffba_walk.sv */
// Header walk sequencer: lays out the heap, runs first-fit allocate and merging free.
module ffba_walk
    import ffba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    input  logic     take,
    output logic     idle,
    output logic     done,
    output res_t     res,
    output mem_req_t mem_req,
    input  header_t  rdata
);

    walk_state_t   state_reg, state_next;
    logic          started_reg, started_next;
    cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] ph_addr_reg, ph_addr_next;
    header_t       ph_reg, ph_next;
    logic          has_prev_reg, has_prev_next;
    header_t       m_reg, m_next;
    logic [AW-1:0] fin_reg, fin_next;
    header_t       finh_reg, finh_next;
    logic [AW-1:0] msz_reg, msz_next;
    logic [AW-1:0] val_reg, val_next;
    logic          mnext_reg, mnext_next;
    res_t          res_reg, res_next;

    logic [AW:0]   nxt;
    logic [AW:0]   aft;
    logic [AW-1:0] mid_size;
    logic [AW-1:0] new_psz;
    logic [WANT_W-1:0] size_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        h_reg        <= h_next;
        ph_addr_reg  <= ph_addr_next;
        ph_reg       <= ph_next;
        has_prev_reg <= has_prev_next;
        m_reg        <= m_next;
        fin_reg      <= fin_next;
        finh_reg     <= finh_next;
        msz_reg      <= msz_next;
        val_reg      <= val_next;
        mnext_reg    <= mnext_next;
        res_reg      <= res_next;
    end

    assign nxt      = follow_hdr(h_reg, rdata.size);
    assign aft      = follow_hdr(fin_reg, rdata.size);
    assign size_ext = {{(WANT_W-AW){1'b0}}, rdata.size};
    assign mid_size = m_reg.size - cmd_reg.want[AW-1:0] - {{(AW-1){1'b0}}, 1'b1};
    assign new_psz  = ph_reg.size + msz_reg + {{(AW-1){1'b0}}, 1'b1};

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        cmd_next      = cmd_reg;
        h_next        = h_reg;
        ph_addr_next  = ph_addr_reg;
        ph_next       = ph_reg;
        has_prev_next = has_prev_reg;
        m_next        = m_reg;
        fin_next      = fin_reg;
        finh_next     = finh_reg;
        msz_next      = msz_reg;
        val_next      = val_reg;
        mnext_next    = mnext_reg;
        res_next      = res_reg;
        mem_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = started_reg ? S_START : S_INIT0;
                end
            end
            S_INIT0:
            begin
                mem_req.en           = 1'b1;
                mem_req.we           = 1'b1;
                mem_req.addr         = '0;
                mem_req.wdata.size   = AW'(HEAP_GRANULES - 2);
                mem_req.wdata.prev   = '0;
                mem_req.wdata.status = ST_FREE;
                state_next           = S_INIT1;
            end
            S_INIT1:
            begin
                mem_req.en           = 1'b1;
                mem_req.we           = 1'b1;
                mem_req.addr         = AW'(HEAP_GRANULES - 1);
                mem_req.wdata.size   = '0;
                mem_req.wdata.prev   = AW'(HEAP_GRANULES - 2);
                mem_req.wdata.status = ST_LAST;
                started_next         = 1'b1;
                state_next           = S_START;
            end
            S_START:
            begin
                res_next = '0;
                if (cmd_reg.op == OP_FREE && cmd_reg.null_free)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.en    = 1'b1;
                    mem_req.addr  = '0;
                    h_next        = '0;
                    has_prev_next = 1'b0;
                    state_next    = S_CHK;
                end
            end
            S_CHK:
            begin
                if (rdata.status == ST_LAST)
                begin
                    res_next.status = (cmd_reg.op == OP_ALLOC);
                    state_next      = S_DONE;
                end
                else if (cmd_reg.op == OP_ALLOC)
                begin
                    if (rdata.status == ST_FREE && size_ext == cmd_reg.want)
                    begin
                        mem_req.en           = 1'b1;
                        mem_req.we           = 1'b1;
                        mem_req.addr         = h_reg;
                        mem_req.wdata        = rdata;
                        mem_req.wdata.status = ST_INUSE;
                        res_next.addr        = h_reg + {{(AW-1){1'b0}}, 1'b1};
                        state_next           = S_DONE;
                    end
                    else if (past_end(nxt))
                    begin
                        res_next.status = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        mem_req.en   = 1'b1;
                        mem_req.addr = nxt[AW-1:0];
                        if (rdata.status == ST_FREE && size_ext > cmd_reg.want)
                        begin
                            m_next     = rdata;
                            fin_next   = nxt[AW-1:0];
                            state_next = S_A_NX;
                        end
                        else
                        begin
                            h_next = nxt[AW-1:0];
                        end
                    end
                end
                else
                begin
                    if (h_reg == cmd_reg.target)
                    begin
                        if (rdata.status != ST_INUSE || past_end(nxt))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = nxt[AW-1:0];
                            m_next       = rdata;
                            fin_next     = nxt[AW-1:0];
                            state_next   = S_F_NX;
                        end
                    end
                    else if (past_end(nxt))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ph_next       = rdata;
                        ph_addr_next  = h_reg;
                        has_prev_next = 1'b1;
                        mem_req.en    = 1'b1;
                        mem_req.addr  = nxt[AW-1:0];
                        h_next        = nxt[AW-1:0];
                    end
                end
            end
            S_A_NX:
            begin
                finh_next            = rdata;
                mem_req.en           = 1'b1;
                mem_req.we           = 1'b1;
                mem_req.addr         = h_reg + cmd_reg.want[AW-1:0] + {{(AW-1){1'b0}}, 1'b1};
                mem_req.wdata.size   = mid_size;
                mem_req.wdata.prev   = cmd_reg.want[AW-1:0];
                mem_req.wdata.status = ST_FREE;
                state_next           = S_A_W1;
            end
            S_A_W1:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = fin_reg;
                mem_req.wdata      = finh_reg;
                mem_req.wdata.prev = mid_size;
                state_next         = S_A_W2;
            end
            S_A_W2:
            begin
                mem_req.en           = 1'b1;
                mem_req.we           = 1'b1;
                mem_req.addr         = h_reg;
                mem_req.wdata.size   = cmd_reg.want[AW-1:0];
                mem_req.wdata.prev   = m_reg.prev;
                mem_req.wdata.status = ST_INUSE;
                res_next.addr        = h_reg + {{(AW-1){1'b0}}, 1'b1};
                state_next           = S_DONE;
            end
            S_F_NX:
            begin
                if (rdata.status == ST_FREE)
                begin
                    if (past_end(aft))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        msz_next     = m_reg.size + rdata.size + {{(AW-1){1'b0}}, 1'b1};
                        mnext_next   = 1'b1;
                        fin_next     = aft[AW-1:0];
                        mem_req.en   = 1'b1;
                        mem_req.addr = aft[AW-1:0];
                        state_next   = S_F_AF;
                    end
                end
                else
                begin
                    msz_next   = m_reg.size;
                    mnext_next = 1'b0;
                    finh_next  = rdata;
                    state_next = S_F_W1;
                end
            end
            S_F_AF:
            begin
                finh_next  = rdata;
                state_next = S_F_W1;
            end
            S_F_W1:
            begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                if (has_prev_reg && ph_reg.status == ST_FREE)
                begin
                    mem_req.addr       = ph_addr_reg;
                    mem_req.wdata      = ph_reg;
                    mem_req.wdata.size = new_psz;
                    val_next           = new_psz;
                    state_next         = S_F_W2;
                end
                else
                begin
                    mem_req.addr         = h_reg;
                    mem_req.wdata.size   = msz_reg;
                    mem_req.wdata.prev   = m_reg.prev;
                    mem_req.wdata.status = ST_FREE;
                    val_next             = msz_reg;
                    state_next           = mnext_reg ? S_F_W2 : S_DONE;
                end
            end
            S_F_W2:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = fin_reg;
                mem_req.wdata      = finh_reg;
                mem_req.wdata.prev = val_reg;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/first_fit_boundary_tag_allocator.sv */
// Top level of the first-fit boundary-tag heap allocator.
//
//   Port      Dir   Carries
//   request   in    operation, request_bytes, block_address
//   result    out   granted_address, status (one per request)
//
// A result follows a header walk from granule 0, one read per cycle from the single-port
// header memory, and the next request waits until the walk is idle. A split allocate
// adds three header writes; a free of a found block adds a read of the next header,
// another if it merges forward, and one or two writes. The first request after reset
// lays out the heap. Reset clears control state only; the header memory holds garbage
// until written. A result waiting in the output register does not stop the next request.
module first_fit_boundary_tag_allocator
    import ffba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ffba_req_if.sink   request,
    ffba_rsp_if.source result
);

    cmd_t     cmd;
    res_t     res;
    mem_req_t mem_req;
    header_t  rdata;
    logic     idle;
    logic     done;
    logic     take;
    logic     out_valid_reg;
    res_t     out_reg;
    logic [WANT_W-1:0] bytes_ext;

    assign bytes_ext     = {{(WANT_W-BYTES_W){1'b0}}, request.request_bytes};
    assign cmd.op        = op_t'(request.operation);
    assign cmd.want      = (bytes_ext + WANT_W'(GRANULE_BYTES - 1)) >> GSHIFT;
    assign cmd.target    = request.block_address - {{(AW-1){1'b0}}, 1'b1};
    assign cmd.null_free = (request.block_address == '0);

    assign request.ready = idle;
    assign take          = !out_valid_reg || result.ready;

    ffba_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (request.valid && idle),
        .cmd     (cmd),
        .take    (take),
        .idle    (idle),
        .done    (done),
        .res     (res),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    ffba_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && take)
        begin
            out_reg <= res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.granted_address = out_reg.addr;
    assign result.status          = out_reg.status;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("Allocator accepted a request while still busy.");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        done && take |=> result.valid)
        else $error("Finished request did not reach the result register.");

    a_fail_has_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.granted_address == '0)
        else $error("Failed allocate returned a nonzero address.");

    a_mem_idle_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !mem_req.en)
        else $error("Header memory accessed while no request is in progress.");

endmodule
